FILE: sv/crcfr_pkg.sv
`timescale 1ns / 1ps
// Package for the CRC-32 checked frame receiver: codes, register indexes,
// frame layout constants and the byte-wide reflected CRC-32 step.
// No dependencies.
package crcfr_pkg;

    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [7:0]  REPLY_BIT = 8'h80;

    // head1 head2 cmd len_lo len_hi | data | crc[4] tail1 tail2
    localparam int HDR_BYTES      = 5;
    localparam int CRC_BYTES      = 4;
    localparam int FRAME_OVERHEAD = 11;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_BAD_TAIL = 3'd1,
        STATUS_BAD_CRC  = 3'd2,
        STATUS_REPLY    = 3'd3,
        STATUS_TOO_LONG = 3'd4,
        STATUS_GAP      = 3'd5
    } status_t;

    localparam logic [2:0] REG_HEAD_FIRST  = 3'd0;
    localparam logic [2:0] REG_HEAD_SECOND = 3'd1;
    localparam logic [2:0] REG_TAIL_FIRST  = 3'd2;
    localparam logic [2:0] REG_TAIL_SECOND = 3'd3;
    localparam logic [2:0] REG_MAX_LENGTH  = 3'd4;
    localparam logic [2:0] REG_GAP_LIMIT   = 3'd5;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

FILE: sv/crc32_checked_frame_receiver_unit.sv
`timescale 1ns / 1ps
// Top level of the CRC-32 checked frame receiver.
// Depends on crcfr_pkg.
//
// Takes one word per clock: a UART byte or a 1 ms tick. Frames are head1 head2
// cmd len_lo len_hi data[len] crc32_le tail1 tail2; the reflected CRC-32 over
// cmd, length and data is updated one byte per word. Each data byte comes out
// as a payload word as it arrives, and every frame end, too-long length or gap
// abort gives one report word (0 ok, 1 bad tail, 2 CRC mismatch, 3 reply frame,
// 4 too long, 5 gap abort). Every word goes combinationally from the input port
// into the output register, so a new word is taken each cycle; s_ready drops only
// while a result waits in the output register and m_ready is low. Configuration
// writes are taken at once and should be made while the block is idle.
module crc32_checked_frame_receiver_unit (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [2:0]                cfg_index,
    input  logic [15:0]               cfg_data,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_opcode,
    input  logic [7:0]                s_rx_byte,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_result_kind,
    output logic [7:0]                m_payload_byte,
    output logic [15:0]               m_payload_index,
    output logic [7:0]                m_frame_cmd,
    output logic [15:0]               m_frame_length,
    output logic [2:0]                m_frame_status
);
    import crcfr_pkg::*;

    logic [7:0]  head_first_reg, head_second_reg, tail_first_reg, tail_second_reg;
    logic [15:0] max_length_reg, gap_limit_reg;

    logic [16:0] pos_reg, pos_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] rcrc_reg, rcrc_next;
    logic        tail_ok_reg, tail_ok_next;
    logic [15:0] idle_reg, idle_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic [15:0] out_index_reg, out_index_next;
    logic [7:0]  out_cmd_reg, out_cmd_next;
    logic [15:0] out_len_reg, out_len_next;
    status_t     out_status_reg, out_status_next;

    logic        accept;
    logic [17:0] posx, lenx;
    logic [17:0] rel;
    logic [15:0] len_hi_full;
    logic [31:0] crc_step;
    logic        tail_now;

    assign cfg_ready = 1'b1;
    assign s_ready   = !out_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    assign posx        = {1'b0, pos_reg};
    assign lenx        = {2'b00, len_reg};
    assign rel         = posx - 18'(HDR_BYTES) - lenx;
    assign len_hi_full = {s_rx_byte, len_reg[7:0]};
    assign crc_step    = crc32_byte(crc_reg, s_rx_byte);
    assign tail_now    = tail_ok_reg && (s_rx_byte == tail_second_reg);

    always_comb begin
        pos_next        = pos_reg;
        len_next        = len_reg;
        cmd_next        = cmd_reg;
        crc_next        = crc_reg;
        rcrc_next       = rcrc_reg;
        tail_ok_next    = tail_ok_reg;
        idle_next       = idle_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_kind_next   = out_kind_reg;
        out_byte_next   = out_byte_reg;
        out_index_next  = out_index_reg;
        out_cmd_next    = out_cmd_reg;
        out_len_next    = out_len_reg;
        out_status_next = out_status_reg;

        if (accept) begin
            out_byte_next   = 8'd0;
            out_index_next  = 16'd0;
            out_cmd_next    = cmd_reg;
            out_len_next    = len_reg;
            out_kind_next   = KIND_REPORT;
            out_status_next = STATUS_OK;
            if (s_opcode == OP_TICK) begin
                if (idle_reg != 16'hFFFF) begin
                    idle_next = idle_reg + 16'd1;
                end
                if (idle_next > gap_limit_reg && pos_reg != 17'd0) begin
                    pos_next        = 17'd0;
                    out_valid_next  = 1'b1;
                    out_status_next = STATUS_GAP;
                end
            end else begin
                idle_next = 16'd0;
                if (pos_reg == 17'd0 || posx > lenx + 18'(FRAME_OVERHEAD - 1)) begin
                    pos_next = 17'd0;
                    if (s_rx_byte == head_first_reg) begin
                        pos_next     = 17'd1;
                        cmd_next     = 8'd0;
                        len_next     = 16'd0;
                        rcrc_next    = 32'd0;
                        crc_next     = CRC_INIT;
                        tail_ok_next = 1'b0;
                    end
                end else if (pos_reg == 17'd1) begin
                    if (s_rx_byte == head_second_reg) begin
                        pos_next = 17'd2;
                    end else if (s_rx_byte == head_first_reg) begin
                        pos_next = 17'd1;
                    end else begin
                        pos_next = 17'd0;
                    end
                end else if (pos_reg == 17'd2) begin
                    cmd_next = s_rx_byte;
                    crc_next = crc_step;
                    pos_next = 17'd3;
                end else if (pos_reg == 17'd3) begin
                    len_next = {8'd0, s_rx_byte};
                    crc_next = crc_step;
                    pos_next = 17'd4;
                end else if (pos_reg == 17'd4) begin
                    len_next = len_hi_full;
                    crc_next = crc_step;
                    pos_next = 17'd5;
                    if (len_hi_full > max_length_reg) begin
                        pos_next        = 17'd0;
                        out_valid_next  = 1'b1;
                        out_len_next    = len_hi_full;
                        out_status_next = STATUS_TOO_LONG;
                    end
                end else if (posx < lenx + 18'(HDR_BYTES)) begin
                    crc_next       = crc_step;
                    pos_next       = pos_reg + 17'd1;
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_PAYLOAD;
                    out_byte_next  = s_rx_byte;
                    out_index_next = 16'(pos_reg - 17'(HDR_BYTES));
                end else if (posx < lenx + 18'(HDR_BYTES + CRC_BYTES)) begin
                    case (rel[1:0])
                        2'd0: rcrc_next[7:0]   = s_rx_byte;
                        2'd1: rcrc_next[15:8]  = s_rx_byte;
                        2'd2: rcrc_next[23:16] = s_rx_byte;
                        2'd3: rcrc_next[31:24] = s_rx_byte;
                        default: rcrc_next = rcrc_reg;
                    endcase
                    pos_next = pos_reg + 17'd1;
                end else if (posx == lenx + 18'(HDR_BYTES + CRC_BYTES)) begin
                    tail_ok_next = (s_rx_byte == tail_first_reg);
                    pos_next     = pos_reg + 17'd1;
                end else begin
                    tail_ok_next   = tail_now;
                    pos_next       = 17'd0;
                    out_valid_next = 1'b1;
                    if (!tail_now) begin
                        out_status_next = STATUS_BAD_TAIL;
                    end else if ((cmd_reg & REPLY_BIT) != 8'd0) begin
                        out_status_next = STATUS_REPLY;
                    end else if (~crc_reg != rcrc_reg) begin
                        out_status_next = STATUS_BAD_CRC;
                    end else begin
                        out_status_next = STATUS_OK;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_first_reg  <= 8'hAA;
            head_second_reg <= 8'h55;
            tail_first_reg  <= 8'h55;
            tail_second_reg <= 8'hAA;
            max_length_reg  <= 16'd260;
            gap_limit_reg   <= 16'd50;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_HEAD_FIRST:  head_first_reg  <= cfg_data[7:0];
                REG_HEAD_SECOND: head_second_reg <= cfg_data[7:0];
                REG_TAIL_FIRST:  tail_first_reg  <= cfg_data[7:0];
                REG_TAIL_SECOND: tail_second_reg <= cfg_data[7:0];
                REG_MAX_LENGTH:  max_length_reg  <= cfg_data;
                REG_GAP_LIMIT:   gap_limit_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= 17'd0;
            len_reg       <= 16'd0;
            cmd_reg       <= 8'd0;
            crc_reg       <= CRC_INIT;
            rcrc_reg      <= 32'd0;
            tail_ok_reg   <= 1'b0;
            idle_reg      <= 16'd0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            cmd_reg       <= cmd_next;
            crc_reg       <= crc_next;
            rcrc_reg      <= rcrc_next;
            tail_ok_reg   <= tail_ok_next;
            idle_reg      <= idle_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_kind_reg   <= out_kind_next;
        out_byte_reg   <= out_byte_next;
        out_index_reg  <= out_index_next;
        out_cmd_reg    <= out_cmd_next;
        out_len_reg    <= out_len_next;
        out_status_reg <= out_status_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_result_kind   = out_kind_reg;
    assign m_payload_byte  = out_byte_reg;
    assign m_payload_index = out_index_reg;
    assign m_frame_cmd     = out_cmd_reg;
    assign m_frame_length  = out_len_reg;
    assign m_frame_status  = out_status_reg;

endmodule

FILE: sv/crcfr_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the CRC-32 checked frame receiver, bound to the top.
// Depends on crcfr_pkg and crc32_checked_frame_receiver_unit.
module crcfr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_result_kind,
    input logic [7:0]  m_payload_byte,
    input logic [15:0] m_payload_index,
    input logic [7:0]  m_frame_cmd,
    input logic [15:0] m_frame_length,
    input logic [2:0]  m_frame_status
);
    import crcfr_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_kind) &&
        $stable(m_payload_byte) && $stable(m_payload_index) &&
        $stable(m_frame_cmd) && $stable(m_frame_length) && $stable(m_frame_status))
        else $error("result word changed while stalled");

    a_payload_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == KIND_PAYLOAD |->
        m_frame_status == STATUS_OK && m_payload_index < m_frame_length)
        else $error("payload word with bad status or index past length");

    a_report_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == KIND_REPORT |->
        m_payload_byte == 8'd0 && m_payload_index == 16'd0 &&
        m_frame_status <= STATUS_GAP)
        else $error("report word carries payload fields or unknown status");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("result word without an accepted input word");

endmodule

bind crc32_checked_frame_receiver_unit crcfr_checker u_crcfr_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_result_kind   (m_result_kind),
    .m_payload_byte  (m_payload_byte),
    .m_payload_index (m_payload_index),
    .m_frame_cmd     (m_frame_cmd),
    .m_frame_length  (m_frame_length),
    .m_frame_status  (m_frame_status)
);
